// File: rtl/core/ppc_pkg.sv
// shared types, codes and helpers for the palette pixel compositor
`timescale 1ns / 1ps

package ppc_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int ADDRESS_BITS    = 24;

   localparam int COLOR_BITS   = 8;
   localparam int RGB_BITS     = 3 * COLOR_BITS;
   localparam int POS_BITS     = 12;
   localparam int SIZE_BITS    = 13;
   localparam int TRANSP_BITS  = 9;
   localparam int INDEX_BITS   = 8;
   localparam int OUT_ADDR_BITS = 24;
   localparam int PRODUCT_BITS = 2 * SIZE_BITS;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = SIZE_BITS;

   localparam logic [SIZE_BITS-1:0]   SIZE_MAX     = 13'd4096;
   localparam logic [COLOR_BITS-1:0]  ALPHA_OPAQUE = 8'hFF;
   localparam logic [TRANSP_BITS-1:0] TRANSP_NONE  = 9'd256;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_DRAW    = 2'd1,
      CMD_CLEAR   = 2'd2,
      CMD_RESTART = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_ROW_STRIDE        = 3'd0,
      REG_SCREEN_WIDTH      = 3'd1,
      REG_SCREEN_HEIGHT     = 3'd2,
      REG_FRAME_LEFT        = 3'd3,
      REG_FRAME_TOP         = 3'd4,
      REG_FRAME_WIDTH       = 3'd5,
      REG_FRAME_HEIGHT      = 3'd6,
      REG_TRANSPARENT_INDEX = 3'd7
   } reg_index_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic [INDEX_BITS-1:0]   pixel_index;
      logic [COLOR_BITS-1:0]   load_red;
      logic [COLOR_BITS-1:0]   load_green;
      logic [COLOR_BITS-1:0]   load_blue;
   } req_type;

   typedef struct packed {
      logic                     write_valid;
      logic [OUT_ADDR_BITS-1:0] write_address;
      logic [COLOR_BITS-1:0]    out_alpha;
      logic [COLOR_BITS-1:0]    out_red;
      logic [COLOR_BITS-1:0]    out_green;
      logic [COLOR_BITS-1:0]    out_blue;
      logic                     region_done;
   } rsp_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0]   row_stride;
      logic [SIZE_BITS-1:0]   screen_width;
      logic [SIZE_BITS-1:0]   screen_height;
      logic [POS_BITS-1:0]    frame_left;
      logic [POS_BITS-1:0]    frame_top;
      logic [SIZE_BITS-1:0]   frame_width;
      logic [SIZE_BITS-1:0]   frame_height;
      logic [TRANSP_BITS-1:0] transparent_index;
   } cfg_type;

   typedef struct packed {
      logic                 write_valid;
      logic                 is_draw;
      logic                 region_done;
      logic                 black;
      logic [SIZE_BITS-1:0] srow;
      logic [SIZE_BITS-1:0] scol;
   } s1_type;

   typedef struct packed {
      logic                    write_valid;
      logic                    is_draw;
      logic                    region_done;
      logic [PRODUCT_BITS-1:0] product;
      logic [SIZE_BITS-1:0]    scol;
      logic [RGB_BITS-1:0]     color;
   } s2_type;

   function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] v);
      logic [SIZE_BITS-1:0] r;
      if (v == '0) begin
         r = SIZE_BITS'(1);
      end else if (v > SIZE_MAX) begin
         r = SIZE_MAX;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// File: rtl/core/ppc_csr.sv
// configuration registers, sizes stored already clamped
`timescale 1ns / 1ps

module ppc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [ppc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ppc_pkg::CSR_DATA_BITS-1:0]    csr_write_data,
   output ppc_pkg::cfg_type                     cfg
);

   ppc_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (ppc_pkg::reg_index_type'(csr_index))
            ppc_pkg::REG_ROW_STRIDE:
               cfg_in.row_stride = ppc_pkg::clamp_size(csr_write_data);
            ppc_pkg::REG_SCREEN_WIDTH:
               cfg_in.screen_width = ppc_pkg::clamp_size(csr_write_data);
            ppc_pkg::REG_SCREEN_HEIGHT:
               cfg_in.screen_height = ppc_pkg::clamp_size(csr_write_data);
            ppc_pkg::REG_FRAME_LEFT:
               cfg_in.frame_left = csr_write_data[ppc_pkg::POS_BITS-1:0];
            ppc_pkg::REG_FRAME_TOP:
               cfg_in.frame_top = csr_write_data[ppc_pkg::POS_BITS-1:0];
            ppc_pkg::REG_FRAME_WIDTH:
               cfg_in.frame_width = ppc_pkg::clamp_size(csr_write_data);
            ppc_pkg::REG_FRAME_HEIGHT:
               cfg_in.frame_height = ppc_pkg::clamp_size(csr_write_data);
            ppc_pkg::REG_TRANSPARENT_INDEX:
               cfg_in.transparent_index = csr_write_data[ppc_pkg::TRANSP_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_stride        <= ppc_pkg::SIZE_BITS'(1);
         cfg_ff.screen_width      <= ppc_pkg::SIZE_BITS'(1);
         cfg_ff.screen_height     <= ppc_pkg::SIZE_BITS'(1);
         cfg_ff.frame_left        <= '0;
         cfg_ff.frame_top         <= '0;
         cfg_ff.frame_width       <= ppc_pkg::SIZE_BITS'(1);
         cfg_ff.frame_height      <= ppc_pkg::SIZE_BITS'(1);
         cfg_ff.transparent_index <= ppc_pkg::TRANSP_NONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/ppc_palette.sv
// palette memory with per-entry written bits over a greyscale reset ramp
`timescale 1ns / 1ps

module ppc_palette #(
   parameter  int PALETTE_ENTRIES = ppc_pkg::PALETTE_ENTRIES,
   localparam int IndexBits = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [IndexBits-1:0]          wr_idx,
   input  logic [ppc_pkg::RGB_BITS-1:0]  wr_data,
   input  logic                          rd_en,
   input  logic [IndexBits-1:0]          rd_idx,
   output logic [ppc_pkg::RGB_BITS-1:0]  rd_color
);

   logic [ppc_pkg::RGB_BITS-1:0]   mem_ff [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0]     written_ff, written_in;
   logic [ppc_pkg::RGB_BITS-1:0]   rd_data_ff;
   logic                           rd_written_ff;
   logic [IndexBits-1:0]           rd_idx_ff;
   logic [ppc_pkg::COLOR_BITS-1:0] ramp;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff    <= mem_ff[rd_idx];
         rd_written_ff <= written_ff[rd_idx];
         rd_idx_ff     <= rd_idx;
      end
   end

   always_comb begin
      written_in = written_ff;
      if (wr_en) begin
         written_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else begin
         written_ff <= written_in;
      end
   end

   assign ramp     = ppc_pkg::COLOR_BITS'(rd_idx_ff);
   assign rd_color = rd_written_ff ? rd_data_ff : {ramp, ramp, ramp};

endmodule

// File: rtl/core/ppc_locate.sv
// position stepper, transparency and clip decisions, first pipeline register
`timescale 1ns / 1ps

module ppc_locate #(
   parameter int PALETTE_ENTRIES = ppc_pkg::PALETTE_ENTRIES
) (
   input  logic              clock,
   input  logic              reset,
   input  ppc_pkg::cfg_type  cfg,
   input  logic              req_valid,
   input  ppc_pkg::req_type  req_payload,
   input  logic              s1_en,
   output logic              s1_valid,
   output ppc_pkg::s1_type   s1
);

   localparam int SB = ppc_pkg::SIZE_BITS;
   localparam int PB = ppc_pkg::POS_BITS;

   logic [PB-1:0]  column_pos_ff, column_pos_in;
   logic [PB-1:0]  row_pos_ff, row_pos_in;
   logic           s1_v_ff, s1_v_in;
   ppc_pkg::s1_type s1_ff, s1_in;

   logic           take;
   logic           is_draw, is_clear, is_pixel;
   logic [SB-1:0]  col, row, col_next, row_next, scol, srow;
   logic           last, transparent, on_screen;

   assign take     = req_valid && s1_en;
   assign is_draw  = (req_payload.cmd == ppc_pkg::CMD_DRAW);
   assign is_clear = (req_payload.cmd == ppc_pkg::CMD_CLEAR);
   assign is_pixel = is_draw || is_clear;

   // position may sit outside a rectangle shrunk since the last step
   assign col = (SB'(column_pos_ff) >= cfg.frame_width)  ? '0 : SB'(column_pos_ff);
   assign row = (SB'(row_pos_ff)    >= cfg.frame_height) ? '0 : SB'(row_pos_ff);
   assign col_next = col + SB'(1);
   assign row_next = row + SB'(1);
   assign scol = SB'(cfg.frame_left) + col;
   assign srow = SB'(cfg.frame_top) + row;
   assign last = (col_next == cfg.frame_width) && (row_next == cfg.frame_height);

   assign transparent = ({1'b0, req_payload.pixel_index} == cfg.transparent_index);
   assign on_screen   = (scol < cfg.screen_width) && (srow < cfg.screen_height);

   always_comb begin
      column_pos_in = column_pos_ff;
      row_pos_in    = row_pos_ff;
      if (take) begin
         if (req_payload.cmd == ppc_pkg::CMD_RESTART) begin
            column_pos_in = '0;
            row_pos_in    = '0;
         end else if (is_pixel) begin
            if (col_next < cfg.frame_width) begin
               column_pos_in = col_next[PB-1:0];
               row_pos_in    = row[PB-1:0];
            end else begin
               column_pos_in = '0;
               row_pos_in    = (row_next < cfg.frame_height) ? row_next[PB-1:0] : '0;
            end
         end
      end
   end

   always_comb begin
      s1_v_in           = s1_en ? req_valid : s1_v_ff;
      s1_in.is_draw     = is_draw;
      s1_in.region_done = is_pixel && last;
      s1_in.write_valid = (is_draw && !transparent) || (is_clear && on_screen);
      s1_in.black       = ({1'b0, req_payload.pixel_index} >=
                           (ppc_pkg::INDEX_BITS + 1)'(PALETTE_ENTRIES));
      s1_in.srow        = srow;
      s1_in.scol        = scol;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_pos_ff <= '0;
         row_pos_ff    <= '0;
         s1_v_ff       <= 1'b0;
      end else begin
         column_pos_ff <= column_pos_in;
         row_pos_ff    <= row_pos_in;
         s1_v_ff       <= s1_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_ff <= s1_in;
      end
   end

   assign s1_valid = s1_v_ff;
   assign s1       = s1_ff;

endmodule

// File: rtl/core/ppc_emit.sv
// row multiply stage, address add and the result register
`timescale 1ns / 1ps

module ppc_emit #(
   parameter int ADDRESS_BITS = ppc_pkg::ADDRESS_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [ppc_pkg::SIZE_BITS-1:0]       row_stride,
   input  logic                                s1_valid,
   input  ppc_pkg::s1_type                     s1,
   input  logic [ppc_pkg::RGB_BITS-1:0]        palette_color,
   output logic                                s2_en,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ppc_pkg::rsp_type                    rsp_payload
);

   localparam int PRB  = ppc_pkg::PRODUCT_BITS;
   localparam int SumBits = PRB + 1;
   localparam int OAB  = ppc_pkg::OUT_ADDR_BITS;
   localparam logic [OAB-1:0] AddrKeep =
      (ADDRESS_BITS >= OAB) ? '1 : OAB'((64'd1 << ADDRESS_BITS) - 64'd1);

   logic             s2_v_ff, s2_v_in;
   ppc_pkg::s2_type  s2_ff, s2_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ppc_pkg::rsp_type rsp_ff, rsp_in;
   logic             out_en;
   logic [SumBits-1:0] sum;
   logic             draw_write;

   assign out_en = !rsp_valid_ff || !rsp_stall;
   assign s2_en  = !s2_v_ff || out_en;

   always_comb begin
      s2_v_in           = s2_en ? s1_valid : s2_v_ff;
      s2_in.write_valid = s1.write_valid;
      s2_in.is_draw     = s1.is_draw;
      s2_in.region_done = s1.region_done;
      s2_in.product     = PRB'(s1.srow) * PRB'(row_stride);
      s2_in.scol        = s1.scol;
      s2_in.color       = s1.black ? '0 : palette_color;
   end

   assign sum        = {1'b0, s2_ff.product} + SumBits'(s2_ff.scol);
   assign draw_write = s2_ff.write_valid && s2_ff.is_draw;

   always_comb begin
      rsp_valid_in          = out_en ? s2_v_ff : rsp_valid_ff;
      rsp_in.write_valid    = s2_ff.write_valid;
      rsp_in.write_address  = s2_ff.write_valid ? (sum[OAB-1:0] & AddrKeep) : '0;
      rsp_in.out_alpha      = draw_write ? ppc_pkg::ALPHA_OPAQUE : '0;
      rsp_in.out_red        = draw_write ? s2_ff.color[23:16] : '0;
      rsp_in.out_green      = draw_write ? s2_ff.color[15:8] : '0;
      rsp_in.out_blue       = draw_write ? s2_ff.color[7:0] : '0;
      rsp_in.region_done    = s2_ff.region_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_v_ff      <= s2_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_ff <= s2_in;
      end
      if (out_en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: rtl/core/palette_pixel_compositor_core.sv
// top level of the palette pixel compositor
// throughput: one request per cycle while results are not stalled; stages, each registered,
// are position/palette read, row multiply, address add
// every request gives one result; a stalled result holds and the stages behind it keep filling
// synchronous reset: position to origin, registers to defaults, palette reads as greyscale ramp
// the palette needs no clearing pass; per-entry written bits are cleared by reset at once
`timescale 1ns / 1ps

module palette_pixel_compositor_core #(
   parameter int PALETTE_ENTRIES = ppc_pkg::PALETTE_ENTRIES,
   parameter int ADDRESS_BITS    = ppc_pkg::ADDRESS_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ppc_pkg::req_type                    req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ppc_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_write_enable,
   input  logic [ppc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ppc_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);

   localparam int IndexBits = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

   ppc_pkg::cfg_type             cfg;
   ppc_pkg::s1_type              s1;
   logic                         s1_valid, s1_en, s2_en;
   logic                         pal_wr_en;
   logic [ppc_pkg::RGB_BITS-1:0] pal_color;
   logic [IndexBits-1:0]         pal_idx;

   assign s1_en     = !s1_valid || s2_en;
   assign req_stall = !s1_en;
   assign pal_idx   = req_payload.pixel_index[IndexBits-1:0];
   assign pal_wr_en = req_valid && s1_en && (req_payload.cmd == ppc_pkg::CMD_LOAD) &&
                      ({1'b0, req_payload.pixel_index} <
                       (ppc_pkg::INDEX_BITS + 1)'(PALETTE_ENTRIES));

   ppc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   ppc_palette #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_palette (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (pal_wr_en),
      .wr_idx   (pal_idx),
      .wr_data  ({req_payload.load_red, req_payload.load_green, req_payload.load_blue}),
      .rd_en    (s1_en),
      .rd_idx   (pal_idx),
      .rd_color (pal_color)
   );

   ppc_locate #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_locate (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .s1_en       (s1_en),
      .s1_valid    (s1_valid),
      .s1          (s1)
   );

   ppc_emit #(
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_emit (
      .clock         (clock),
      .reset         (reset),
      .row_stride    (cfg.row_stride),
      .s1_valid      (s1_valid),
      .s1            (s1),
      .palette_color (pal_color),
      .s2_en         (s2_en),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload)
   );

endmodule

// File: dv/tb_top.sv
// self-checking testbench for the palette pixel compositor core
`timescale 1ns / 1ps

module tb_top;
   import ppc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 90;
   localparam int BURST_ITEMS = 40;

   typedef struct packed {
      logic [12:0] stride;
      logic [12:0] scr_w;
      logic [12:0] scr_h;
      logic [12:0] left;
      logic [12:0] top;
      logic [12:0] fw;
      logic [12:0] fh;
      logic [12:0] transp;
   } setting_type;

   typedef struct packed {
      req_type stim;
      bit      typed;
      rsp_type want;
   } table_row_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   req_type                    req_payload;
   logic                       rsp_valid;
   logic                       rsp_stall;
   rsp_type                    rsp_payload;
   logic                       csr_write_enable;
   logic [CSR_INDEX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0]   csr_write_data;

   // predictor state
   logic [RGB_BITS-1:0] palette_shadow [PALETTE_ENTRIES];
   logic [POS_BITS-1:0] scan_col;
   logic [POS_BITS-1:0] scan_row;
   cfg_type             shadow_cfg;

   rsp_type expected_pixels [$];
   int      mismatches;
   int      cycle_count;
   int      rsp_wait;
   bit      long_hold_due;
   bit      req_idle_on;
   bit      rsp_idle_on;

   palette_pixel_compositor_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic int unsigned eff_size(input logic [SIZE_BITS-1:0] v);
      int unsigned s;
      s = 32'(v);
      if (s == 0) s = 1;
      else if (s > 4096) s = 4096;
      return s;
   endfunction

   function automatic rsp_type composite_pixel(input req_type r);
      rsp_type         o;
      int unsigned     stride, scr_w, scr_h, fw, fh, col, row, scol, srow;
      longint unsigned addr;
      logic [23:0]     rgb;
      o = '0;
      stride = eff_size(shadow_cfg.row_stride);
      scr_w  = eff_size(shadow_cfg.screen_width);
      scr_h  = eff_size(shadow_cfg.screen_height);
      fw     = eff_size(shadow_cfg.frame_width);
      fh     = eff_size(shadow_cfg.frame_height);
      case (r.cmd)
         CMD_LOAD: begin
            if (32'(r.pixel_index) < PALETTE_ENTRIES) begin
               palette_shadow[r.pixel_index] = {r.load_red, r.load_green, r.load_blue};
            end
         end
         CMD_RESTART: begin
            scan_col = '0;
            scan_row = '0;
         end
         default: begin
            col = 32'(scan_col);
            row = 32'(scan_row);
            if (col >= fw) col = 0;
            if (row >= fh) row = 0;
            scol = 32'(shadow_cfg.frame_left) + col;
            srow = 32'(shadow_cfg.frame_top) + row;
            if (r.cmd == CMD_DRAW) begin
               if ({1'b0, r.pixel_index} != shadow_cfg.transparent_index) begin
                  rgb = (32'(r.pixel_index) < PALETTE_ENTRIES) ?
                        palette_shadow[r.pixel_index] : '0;
                  o.write_valid = 1'b1;
                  o.out_alpha   = ALPHA_OPAQUE;
                  o.out_red     = rgb[23:16];
                  o.out_green   = rgb[15:8];
                  o.out_blue    = rgb[7:0];
               end
            end else if (scol < scr_w && srow < scr_h) begin
               o.write_valid = 1'b1;
            end
            if (o.write_valid) begin
               addr = (64'(srow) * 64'(stride) + 64'(scol)) &
                      ((64'd1 << ADDRESS_BITS) - 64'd1);
               o.write_address = addr[23:0];
            end
            o.region_done = (col + 1 == fw) && (row + 1 == fh);
            if (col + 1 < fw) begin
               col++;
            end else begin
               col = 0;
               row = (row + 1 < fh) ? row + 1 : 0;
            end
            scan_col = col[POS_BITS-1:0];
            scan_row = row[POS_BITS-1:0];
         end
      endcase
      return o;
   endfunction

   function automatic rsp_type pixel_write(input bit wv, input logic [23:0] addr,
         input logic [7:0] a, red, green, blue, input bit done);
      rsp_type o;
      o.write_valid   = wv;
      o.write_address = addr;
      o.out_alpha     = a;
      o.out_red       = red;
      o.out_green     = green;
      o.out_blue      = blue;
      o.region_done   = done;
      return o;
   endfunction

   function automatic table_row_type table_row(input cmd_type c, input logic [7:0] idx,
         red, green, blue, input bit typed, input rsp_type want);
      table_row_type t;
      t.stim.cmd         = c;
      t.stim.pixel_index = idx;
      t.stim.load_red    = red;
      t.stim.load_green  = green;
      t.stim.load_blue   = blue;
      t.typed            = typed;
      t.want             = want;
      return t;
   endfunction

   function automatic req_type random_request(input cmd_type c);
      req_type r;
      r.cmd         = c;
      r.pixel_index = 8'($urandom);
      r.load_red    = 8'($urandom);
      r.load_green  = 8'($urandom);
      r.load_blue   = 8'($urandom);
      // aim some draws at the transparent color
      if (c == CMD_DRAW && !shadow_cfg.transparent_index[8] && $urandom_range(0, 4) == 0) begin
         r.pixel_index = shadow_cfg.transparent_index[7:0];
      end
      return r;
   endfunction

   function automatic logic [12:0] pick_value(input int unsigned lo, hi, edge_a, edge_b);
      logic [12:0] v;
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 7) v = 13'($urandom_range(lo, hi));
      else if (roll == 7) v = 13'(edge_a);
      else if (roll == 8) v = 13'(edge_b);
      else v = 13'($urandom);
      return v;
   endfunction

   task automatic check_field(input string name, input longint unsigned want, got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $error("result with no pending request");
            mismatches++;
         end else begin
            want = expected_pixels.pop_front();
            check_field("write_valid", 64'(want.write_valid), 64'(rsp_payload.write_valid));
            check_field("write_address", 64'(want.write_address),
                        64'(rsp_payload.write_address));
            check_field("out_alpha", 64'(want.out_alpha), 64'(rsp_payload.out_alpha));
            check_field("out_red", 64'(want.out_red), 64'(rsp_payload.out_red));
            check_field("out_green", 64'(want.out_green), 64'(rsp_payload.out_green));
            check_field("out_blue", 64'(want.out_blue), 64'(rsp_payload.out_blue));
            check_field("region_done", 64'(want.region_done), 64'(rsp_payload.region_done));
         end
         rsp_wait = rsp_idle_on ? $urandom_range(0, 12) : 0;
      end
   end

   initial begin : result_stall_gen
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic push_request(input req_type r, input bit typed, input rsp_type want);
      int      gap;
      rsp_type predicted;
      gap = req_idle_on ? $urandom_range(0, 12) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      predicted = composite_pixel(r);
      expected_pixels.push_back(typed ? want : predicted);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [12:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         REG_ROW_STRIDE:        shadow_cfg.row_stride        = data;
         REG_SCREEN_WIDTH:      shadow_cfg.screen_width      = data;
         REG_SCREEN_HEIGHT:     shadow_cfg.screen_height     = data;
         REG_FRAME_LEFT:        shadow_cfg.frame_left        = data[POS_BITS-1:0];
         REG_FRAME_TOP:         shadow_cfg.frame_top         = data[POS_BITS-1:0];
         REG_FRAME_WIDTH:       shadow_cfg.frame_width       = data;
         REG_FRAME_HEIGHT:      shadow_cfg.frame_height      = data;
         REG_TRANSPARENT_INDEX: shadow_cfg.transparent_index = data[TRANSP_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input setting_type s);
      wait_drained();
      csr_write(REG_ROW_STRIDE, s.stride);
      csr_write(REG_SCREEN_WIDTH, s.scr_w);
      csr_write(REG_SCREEN_HEIGHT, s.scr_h);
      csr_write(REG_FRAME_LEFT, s.left);
      csr_write(REG_FRAME_TOP, s.top);
      csr_write(REG_FRAME_WIDTH, s.fw);
      csr_write(REG_FRAME_HEIGHT, s.fh);
      csr_write(REG_TRANSPARENT_INDEX, s.transp);
   endtask

   // whole-rectangle passes with palette loads, mixed with loose requests
   task automatic run_items(input int n);
      int          sent, area, k, roll;
      cmd_type     c;
      sent = 0;
      while (sent < n) begin
         area = eff_size(shadow_cfg.frame_width) * eff_size(shadow_cfg.frame_height);
         if (area <= 48 && $urandom_range(0, 3) != 0) begin
            push_request(random_request(CMD_RESTART), 1'b0, '0);
            k = $urandom_range(0, 3);
            repeat (k) push_request(random_request(CMD_LOAD), 1'b0, '0);
            repeat (area) push_request(random_request(CMD_DRAW), 1'b0, '0);
            sent += 1 + k + area;
            if ($urandom_range(0, 1) == 0) begin
               repeat (area) push_request(random_request(CMD_CLEAR), 1'b0, '0);
               sent += area;
            end
         end else begin
            repeat (5) begin
               roll = $urandom_range(0, 99);
               if (roll < 15) c = CMD_LOAD;
               else if (roll < 55) c = CMD_DRAW;
               else if (roll < 90) c = CMD_CLEAR;
               else c = CMD_RESTART;
               push_request(random_request(c), 1'b0, '0);
            end
            sent += 5;
         end
      end
   endtask

   initial begin : stimulus
      table_row_type directed_rows [$];
      setting_type   fixed_settings [$];
      setting_type   s;
      int            i;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      mismatches       = 0;
      rsp_wait         = 0;
      long_hold_due    = 1'b0;
      req_idle_on      = 1'b1;
      rsp_idle_on      = 1'b1;
      for (i = 0; i < PALETTE_ENTRIES; i++) palette_shadow[i] = {3{i[7:0]}};
      scan_col = '0;
      scan_row = '0;
      shadow_cfg.row_stride        = 13'd1;
      shadow_cfg.screen_width      = 13'd1;
      shadow_cfg.screen_height     = 13'd1;
      shadow_cfg.frame_left        = '0;
      shadow_cfg.frame_top         = '0;
      shadow_cfg.frame_width       = 13'd1;
      shadow_cfg.frame_height      = 13'd1;
      shadow_cfg.transparent_index = TRANSP_NONE;

      // after reset: 1x1 frame at the origin, greyscale palette, no transparent color
      directed_rows.push_back(table_row(CMD_DRAW, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
         pixel_write(1'b1, 24'd0, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1)));
      directed_rows.push_back(table_row(CMD_DRAW, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1,
         pixel_write(1'b1, 24'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1)));
      directed_rows.push_back(table_row(CMD_DRAW, 8'h80, 8'hFF, 8'hFF, 8'hFF, 1'b1,
         pixel_write(1'b1, 24'd0, 8'hFF, 8'h80, 8'h80, 8'h80, 1'b1)));
      directed_rows.push_back(table_row(CMD_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1,
         pixel_write(1'b1, 24'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1)));
      directed_rows.push_back(table_row(CMD_LOAD, 8'hFF, 8'hFF, 8'h00, 8'hFF, 1'b1, '0));
      directed_rows.push_back(table_row(CMD_LOAD, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b1, '0));
      directed_rows.push_back(table_row(CMD_DRAW, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1,
         pixel_write(1'b1, 24'd0, 8'hFF, 8'hFF, 8'h00, 8'hFF, 1'b1)));
      directed_rows.push_back(table_row(CMD_DRAW, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
         pixel_write(1'b1, 24'd0, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1)));
      directed_rows.push_back(table_row(CMD_RESTART, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, '0));
      directed_rows.push_back(table_row(CMD_LOAD, 8'h5A, 8'hA5, 8'h5A, 8'hC3, 1'b0, '0));
      directed_rows.push_back(table_row(CMD_DRAW, 8'h5A, 8'h00, 8'h00, 8'h00, 1'b0, '0));
      directed_rows.push_back(table_row(CMD_LOAD, 8'h5A, 8'h01, 8'h02, 8'h03, 1'b0, '0));
      directed_rows.push_back(table_row(CMD_DRAW, 8'h5A, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0));
      directed_rows.push_back(table_row(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0));
      directed_rows.push_back(table_row(CMD_RESTART, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0));

      // partial clip, extremes with address wrap, zero sizes, oversize values,
      // rectangle wholly off screen
      fixed_settings.push_back('{13'd5, 13'd4, 13'd3, 13'd2, 13'd1, 13'd3, 13'd3, 13'd7});
      fixed_settings.push_back('{13'd4096, 13'd4096, 13'd4096, 13'd4095, 13'd4095,
                                 13'd4096, 13'd4096, 13'd255});
      fixed_settings.push_back('{13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd256});
      fixed_settings.push_back('{13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF,
                                 13'h1FFF, 13'h1FFF, 13'h1FFF});
      fixed_settings.push_back('{13'd10, 13'd8, 13'd8, 13'd20, 13'd20, 13'd4, 13'd2, 13'd0});

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[j]) push_request(directed_rows[j].stim, directed_rows[j].typed,
                                              directed_rows[j].want);

      foreach (fixed_settings[j]) begin
         apply_setting(fixed_settings[j]);
         req_idle_on = (j % 2 == 0);
         rsp_idle_on = (j % 3 != 1);
         run_items(30);
      end

      for (i = 0; i < 20; i++) begin
         s.stride = pick_value(1, 64, 4096, 0);
         s.scr_w  = pick_value(1, 24, 4096, 0);
         s.scr_h  = pick_value(1, 24, 4096, 0);
         s.left   = pick_value(0, 16, 4095, 0);
         s.top    = pick_value(0, 16, 4095, 0);
         s.fw     = pick_value(1, 8, 0, 8191);
         s.fh     = pick_value(1, 6, 0, 4096);
         s.transp = pick_value(0, 255, 256, 511);
         apply_setting(s);
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         if (i == 4) begin
            // receiver holds off while the sender keeps pushing, then the sender waits
            long_hold_due = 1'b1;
            req_idle_on = 1'b0;
            repeat (BURST_ITEMS) push_request(random_request(CMD_DRAW), 1'b0, '0);
            wait_drained();
            req_idle_on = 1'b1;
         end
         run_items(25);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
